// File: sv/unbounded_knapsack_max_value_unit_defines.svh
// Assertion macros shared by the knapsack unit checker.
`ifndef UNBOUNDED_KNAPSACK_MAX_VALUE_UNIT_DEFINES_SVH
`define UNBOUNDED_KNAPSACK_MAX_VALUE_UNIT_DEFINES_SVH

// Check held only outside reset.
`define UKMV_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ukmv port check failed");

// Check that also spans reset.
`define UKMV_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) disable iff (1'b0) prop) \
    else $error("ukmv reset check failed");

`endif

// File: sv/ukmv_pkg.sv
// Shared types and constants of the knapsack unit.
`default_nettype none
package ukmv_pkg;

  localparam int MAX_BUDGET = 16383;
  localparam int DEPTH      = MAX_BUDGET + 1;
  localparam int ADDR_W     = $clog2(DEPTH);

  localparam int VALUE_W  = 13;
  localparam int PRICE_W  = 14;
  localparam int BUDGET_W = 14;
  localparam int VAL_W    = 28;
  localparam int OUT_W    = 27;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [VAL_W-1:0] TABLE_SAT = {VAL_W{1'b1}};
  localparam logic [VAL_W-1:0] OUT_SAT   = VAL_W'({OUT_W{1'b1}});

  // Register index of budget_cents (paddr[2] selects the register)
  localparam logic REG_BUDGET = 1'b0;

  // One table entry: reachable flag and best value for that spend
  typedef struct packed {
    logic             vld;
    logic [VAL_W-1:0] val;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_SCAN,
    ST_SCAN_DRAIN
  } state_t;

  // Sequencer controls toward the datapath
  typedef struct packed {
    logic              sweep;
    logic              scan;
    logic              clear_we;
    logic              scan_done;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] src;
  } ctl_t;

  // Budget limited to the table size
  function automatic logic [ADDR_W-1:0] clamp_budget(input logic [BUDGET_W-1:0] b);
    logic [31:0] wide;
    wide = 32'(b);
    return (wide > 32'(MAX_BUDGET)) ? ADDR_W'(MAX_BUDGET) : ADDR_W'(wide);
  endfunction

endpackage
`default_nettype wire

// File: sv/ukmv_ram.sv
// Table memory: one write port, two registered read ports.
`default_nettype none
module ukmv_ram (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [ukmv_pkg::ADDR_W-1:0] waddr,
  input  wire ukmv_pkg::entry_t          wdata,
  input  wire logic [ukmv_pkg::ADDR_W-1:0] raddr_a,
  input  wire logic [ukmv_pkg::ADDR_W-1:0] raddr_b,
  output ukmv_pkg::entry_t               rdata_a,
  output ukmv_pkg::entry_t               rdata_b
);

  ukmv_pkg::entry_t mem [ukmv_pkg::DEPTH];

  // Read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

// File: sv/ukmv_alu.sv
// Shared relax unit: saturating add, compare and select.
`default_nettype none
module ukmv_alu (
  input  wire logic                          a_vld,
  input  wire logic [ukmv_pkg::VAL_W-1:0]    a_val,
  input  wire logic [ukmv_pkg::VALUE_W-1:0]  addend,
  input  wire logic                          b_vld,
  input  wire logic [ukmv_pkg::VAL_W-1:0]    b_val,
  output ukmv_pkg::entry_t                   res
);

  logic [ukmv_pkg::VAL_W:0]   sum;
  logic [ukmv_pkg::VAL_W-1:0] cand;
  logic                       take;

  // cand = min(a + addend, saturation); keep it if it beats b
  always_comb begin
    sum  = {1'b0, a_val} + (ukmv_pkg::VAL_W + 1)'(addend);
    cand = sum[ukmv_pkg::VAL_W] ? ukmv_pkg::TABLE_SAT : sum[ukmv_pkg::VAL_W-1:0];
    take = a_vld && (!b_vld || (cand > b_val));
    res.val = take ? cand : b_val;
    res.vld = take || b_vld;
  end

endmodule
`default_nettype wire

// File: sv/ukmv_ctrl.sv
// Sequencer: clear pass, per-item sweep and final scan over the table.
`default_nettype none
module ukmv_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [ukmv_pkg::PRICE_W-1:0]  in_price,
  input  wire logic                          in_last,
  input  wire logic [ukmv_pkg::ADDR_W-1:0]   budget_eff,
  output logic                               busy,
  output ukmv_pkg::ctl_t                     ctl
);

  ukmv_pkg::state_t              state_r, state_nxt;
  logic [ukmv_pkg::ADDR_W-1:0]   cnt_r, cnt_nxt;
  logic [ukmv_pkg::ADDR_W-1:0]   price_r;
  logic                          last_r;
  logic                          accept;
  logic                          price_fits;
  logic                          cnt_at_max;

  assign accept     = start && (state_r == ukmv_pkg::ST_IDLE);
  assign price_fits = (in_price != '0) && (32'(in_price) <= 32'(budget_eff));
  assign cnt_at_max = (cnt_r == ukmv_pkg::ADDR_W'(ukmv_pkg::MAX_BUDGET));

  // Next state and address counter
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ukmv_pkg::ST_CLEAR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_at_max) begin
          state_nxt = ukmv_pkg::ST_IDLE;
          cnt_nxt   = '0;
        end
      end
      ukmv_pkg::ST_IDLE: begin
        cnt_nxt = '0;
        if (accept && price_fits) begin
          state_nxt = ukmv_pkg::ST_SWEEP;
          cnt_nxt   = ukmv_pkg::ADDR_W'(in_price);
        end else if (accept && in_last) begin
          state_nxt = ukmv_pkg::ST_SCAN;
        end
      end
      ukmv_pkg::ST_SWEEP: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == budget_eff) begin
          state_nxt = ukmv_pkg::ST_DRAIN;
          cnt_nxt   = '0;
        end
      end
      ukmv_pkg::ST_DRAIN: begin
        cnt_nxt   = '0;
        state_nxt = last_r ? ukmv_pkg::ST_SCAN : ukmv_pkg::ST_IDLE;
      end
      ukmv_pkg::ST_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_at_max) begin
          state_nxt = ukmv_pkg::ST_SCAN_DRAIN;
          cnt_nxt   = '0;
        end
      end
      ukmv_pkg::ST_SCAN_DRAIN: begin
        cnt_nxt   = '0;
        state_nxt = ukmv_pkg::ST_IDLE;
      end
      default: begin
        cnt_nxt   = '0;
        state_nxt = ukmv_pkg::ST_CLEAR;
      end
    endcase
  end

  // Controls toward the datapath
  always_comb begin
    busy          = (state_r != ukmv_pkg::ST_IDLE);
    ctl.sweep     = (state_r == ukmv_pkg::ST_SWEEP);
    ctl.scan      = (state_r == ukmv_pkg::ST_SCAN);
    ctl.clear_we  = (state_r == ukmv_pkg::ST_SCAN) || (state_r == ukmv_pkg::ST_CLEAR);
    ctl.scan_done = (state_r == ukmv_pkg::ST_SCAN_DRAIN);
    ctl.addr      = cnt_r;
    ctl.src       = cnt_r - price_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ukmv_pkg::ST_CLEAR;
      cnt_r   <= '0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (accept) begin
        last_r <= in_last;
      end
    end
  end

  // Item price held for the source address
  always_ff @(posedge clk) begin
    if (accept) begin
      price_r <= ukmv_pkg::ADDR_W'(in_price);
    end
  end

endmodule
`default_nettype wire

// File: sv/unbounded_knapsack_max_value_unit.sv
// Top level of the unbounded knapsack best-value unit.
// Each item (value, price) runs a read-modify-write sweep over the table of
// best value per exact spend, from its price up to the budget, one entry per
// clock through a two-read, one-write table memory and one shared add/compare
// unit, with busy high through the sweep and its drain state. An item whose
// price is zero or above the budget leaves the table alone. On an item with
// last_item set, a scan over all 16384 entries follows (after the sweep, if
// any), finding the best reachable value while clearing the table, and
// out_strobe marks out_best_value for one cycle in the cycle in which busy
// falls. The receiver cannot stall. After reset the table is cleared with
// busy high; the user must make configuration writes only while the unit is
// idle, as the unit has no guard for this.
`default_nettype none
module unbounded_knapsack_max_value_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Item channel
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [ukmv_pkg::VALUE_W-1:0]   in_item_value,
  input  wire logic [ukmv_pkg::PRICE_W-1:0]   in_item_price_cents,
  input  wire logic                           in_last_item,
  // Result channel
  output logic                                out_strobe,
  output logic [ukmv_pkg::OUT_W-1:0]          out_best_value,
  // Configuration port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [ukmv_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [ukmv_pkg::PDATA_W-1:0]   pwdata,
  output logic [ukmv_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);

  logic [ukmv_pkg::BUDGET_W-1:0] budget_r;
  logic [ukmv_pkg::ADDR_W-1:0]   budget_eff;
  logic [ukmv_pkg::VALUE_W-1:0]  value_r;
  ukmv_pkg::ctl_t                ctl;

  // Pipeline stage between memory read and write-back
  logic                          p1_sweep_r;
  logic                          p1_scan_r;
  logic [ukmv_pkg::ADDR_W-1:0]   p1_addr_r;
  logic [ukmv_pkg::ADDR_W-1:0]   p1_src_r;
  logic                          p1_inrange_r;

  // Last sweep write, forwarded when the next entry reads it
  logic                          wl_vld_r;
  logic [ukmv_pkg::ADDR_W-1:0]   wl_addr_r;
  ukmv_pkg::entry_t              wl_word_r;

  logic [ukmv_pkg::VAL_W-1:0]    max_r, max_nxt;
  logic                          out_strobe_r;
  logic [ukmv_pkg::OUT_W-1:0]    out_best_value_r;

  logic                          ram_we;
  logic [ukmv_pkg::ADDR_W-1:0]   ram_waddr;
  ukmv_pkg::entry_t              ram_wdata;
  logic [ukmv_pkg::ADDR_W-1:0]   ram_raddr_a;
  ukmv_pkg::entry_t              rdata_a, rdata_b;
  ukmv_pkg::entry_t              a_word;

  logic                          alu_a_vld;
  logic [ukmv_pkg::VALUE_W-1:0]  alu_addend;
  logic                          alu_b_vld;
  logic [ukmv_pkg::VAL_W-1:0]    alu_b_val;
  ukmv_pkg::entry_t              alu_res;

  logic                          cfg_wr;
  logic                          accept;

  // Configuration register
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready && (paddr[2] == ukmv_pkg::REG_BUDGET);
  assign prdata  = (paddr[2] == ukmv_pkg::REG_BUDGET) ?
                   ukmv_pkg::PDATA_W'(budget_r) : '0;
  assign budget_eff = ukmv_pkg::clamp_budget(budget_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= '0;
    end else if (cfg_wr) begin
      budget_r <= pwdata[ukmv_pkg::BUDGET_W-1:0];
    end
  end

  // Item value held for the sweep
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (accept) begin
      value_r <= in_item_value;
    end
  end

  ukmv_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_price   (in_item_price_cents),
    .in_last    (in_last_item),
    .budget_eff (budget_eff),
    .busy       (busy),
    .ctl        (ctl)
  );

  // Memory ports: sweep reads source and target; scan and clear share the counter
  always_comb begin
    ram_raddr_a = ctl.sweep ? ctl.src : ctl.addr;
    ram_we      = ctl.clear_we || p1_sweep_r;
    if (ctl.clear_we) begin
      ram_waddr     = ctl.addr;
      ram_wdata.vld = (ctl.addr == '0);
      ram_wdata.val = '0;
    end else begin
      ram_waddr = p1_addr_r;
      ram_wdata = alu_res;
    end
  end

  ukmv_ram u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .raddr_b (ctl.addr),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // Operand select for the shared unit
  always_comb begin
    a_word = rdata_a;
    if (p1_sweep_r && wl_vld_r && (wl_addr_r == p1_src_r)) begin
      a_word = wl_word_r;
    end
    if (p1_scan_r) begin
      alu_a_vld  = a_word.vld && p1_inrange_r;
      alu_addend = '0;
      alu_b_vld  = 1'b1;
      alu_b_val  = max_r;
    end else begin
      alu_a_vld  = a_word.vld;
      alu_addend = value_r;
      alu_b_vld  = rdata_b.vld;
      alu_b_val  = rdata_b.val;
    end
  end

  ukmv_alu u_alu (
    .a_vld  (alu_a_vld),
    .a_val  (a_word.val),
    .addend (alu_addend),
    .b_vld  (alu_b_vld),
    .b_val  (alu_b_val),
    .res    (alu_res)
  );

  // Running maximum during the scan
  assign max_nxt = p1_scan_r ? alu_res.val : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_sweep_r   <= 1'b0;
      p1_scan_r    <= 1'b0;
      wl_vld_r     <= 1'b0;
      max_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      p1_sweep_r   <= ctl.sweep;
      p1_scan_r    <= ctl.scan;
      wl_vld_r     <= p1_sweep_r;
      max_r        <= max_nxt;
      out_strobe_r <= ctl.scan_done;
    end
  end

  always_ff @(posedge clk) begin
    p1_addr_r    <= ctl.addr;
    p1_src_r     <= ctl.src;
    p1_inrange_r <= (ctl.addr <= budget_eff);
    wl_addr_r    <= p1_addr_r;
    wl_word_r    <= alu_res;
    if (ctl.scan_done) begin
      out_best_value_r <= (alu_res.val > ukmv_pkg::OUT_SAT) ?
                          ukmv_pkg::OUT_SAT[ukmv_pkg::OUT_W-1:0] :
                          alu_res.val[ukmv_pkg::OUT_W-1:0];
    end
  end

  assign out_strobe     = out_strobe_r;
  assign out_best_value = out_best_value_r;

endmodule
`default_nettype wire

// File: sv/ukmv_checker.sv
// Port-level checks of the knapsack unit and their binding.
`default_nettype none
`include "unbounded_knapsack_max_value_unit_defines.svh"
module ukmv_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic in_last_item,
  input wire logic out_strobe
);

  // Table clear runs right after reset
  `UKMV_ASSERT_ALWAYS(a_clear_after_reset, !rst_n |=> busy)
  // A taken last beat always makes the unit busy
  `UKMV_ASSERT(a_last_goes_busy, (start && !busy && in_last_item) |=> busy)
  // A result comes just as the unit goes idle
  `UKMV_ASSERT(a_result_at_idle, out_strobe |-> (!busy && $past(busy)))
  // Results never come back to back
  `UKMV_ASSERT(a_single_result, out_strobe |=> !out_strobe)

endmodule

bind unbounded_knapsack_max_value_unit ukmv_checker u_ukmv_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_last_item (in_last_item),
  .out_strobe   (out_strobe)
);
`default_nettype wire
